// ----- hw/rtl/bls_pkg.sv -----
`default_nettype none
package bls_pkg;

	// Built depth default and fixed field widths
	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned CAP_W     = 5;
	localparam int unsigned CMD_W     = 3;
	localparam int unsigned POS_W     = 5;
	localparam int unsigned CNT_OUT_W = 5;
	localparam int unsigned STAT_W    = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TOP    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_BOTTOM = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [STAT_W-1:0] ST_BADPOS    = 2'd3;

	typedef logic [WORD_W-1:0] word_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bounded_lifo_stack_top.sv -----
`default_nettype none
// The done strobe of an accepted command rises in the next cycle.
// Throughput: one command per cycle; busy stays low, since each command makes
// at most one access to the entry memory at its accept edge and writes never collide with reads.
// The receiver cannot stall: every result shows for exactly one cycle.
// Reset clears the entry count and sets capacity to 16; entry contents are undefined.
module bounded_lifo_stack_top #(
	parameter int unsigned DEPTH = bls_pkg::DEPTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Command channel
	input  wire                                 start,
	output logic                                busy,
	input  wire  [bls_pkg::CMD_W-1:0]           cmd,
	input  wire  signed [bls_pkg::WORD_W-1:0]   push_value,
	input  wire  [bls_pkg::POS_W-1:0]           position,
	// Result channel
	output logic                                done,
	output logic signed [bls_pkg::WORD_W-1:0]   value,
	output logic [bls_pkg::STAT_W-1:0]          status,
	output logic                                is_empty,
	output logic                                is_full,
	output logic [bls_pkg::CNT_OUT_W-1:0]       entry_count,
	// Capacity write channel
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [bls_pkg::CAP_W-1:0]           cfg_capacity
);
	import bls_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_nxt;

	logic [XW-1:0]    cnt_x;
	logic [XW-1:0]    pos_x;
	logic [XW-1:0]    cap_x;
	logic [XW-1:0]    eff_cap;
	logic [XW-1:0]    peek_diff;
	logic [XW-1:0]    nxt_x;

	logic             accept;
	logic             wr_en;
	logic             rd_en;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	logic [STAT_W-1:0] stat_nxt;

	word_t            mem_q [DEPTH];
	word_t            rd_data_s1;
	logic             rd_ok_s1;
	logic [STAT_W-1:0] status_s1;
	logic             empty_s1;
	logic             full_s1;
	logic [CW-1:0]    count_s1;
	logic             done_s1;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	// Clamp capacity into 1..DEPTH
	assign cap_x   = XW'(cap_q);
	assign eff_cap = (cap_q == '0) ? XW'(1) : ((cap_x > DEPTH_X) ? DEPTH_X : cap_x);

	assign cnt_x     = XW'(count_q);
	assign pos_x     = XW'(position);
	assign peek_diff = cnt_x - pos_x;

	// Decode command: memory access, next count and status
	always_comb begin
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		wr_addr   = count_q[AW-1:0];
		rd_addr   = '0;
		count_nxt = count_q;
		stat_nxt  = ST_OK;
		case (cmd)
			CMD_PUSH: begin
				if (cnt_x >= eff_cap) begin
					stat_nxt = ST_OVERFLOW;
				end else begin
					wr_en     = 1'b1;
					count_nxt = count_q + CW'(1);
				end
			end
			CMD_POP: begin
				if (count_q == '0) begin
					stat_nxt = ST_UNDERFLOW;
				end else begin
					rd_en     = 1'b1;
					count_nxt = count_q - CW'(1);
					rd_addr   = count_nxt[AW-1:0];
				end
			end
			CMD_PEEK: begin
				if (position == '0 || pos_x > cnt_x) begin
					stat_nxt = ST_BADPOS;
				end else begin
					rd_en   = 1'b1;
					rd_addr = peek_diff[AW-1:0];
				end
			end
			CMD_TOP: begin
				if (count_q == '0) begin
					stat_nxt = ST_UNDERFLOW;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(cnt_x - XW'(1));
				end
			end
			CMD_BOTTOM: begin
				if (count_q == '0) begin
					stat_nxt = ST_UNDERFLOW;
				end else begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			default: begin
				stat_nxt = ST_OK;
			end
		endcase
	end

	assign nxt_x = XW'(count_nxt);

	// Entry memory: write on push, registered read for the other commands
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			mem_q[wr_addr] <= push_value;
		end
		if (accept && rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_capacity;
		end
	end

	// Advance the entry count and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	// Hold the flags of the accepted command for the result cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_s1  <= rd_en;
			status_s1 <= stat_nxt;
			empty_s1  <= (count_nxt == '0);
			full_s1   <= (nxt_x >= eff_cap);
			count_s1  <= count_nxt;
		end
	end

	// Drive the result transaction
	assign done        = done_s1;
	assign value       = rd_ok_s1 ? rd_data_s1 : '0;
	assign status      = status_s1;
	assign is_empty    = empty_s1;
	assign is_full     = full_s1;
	assign entry_count = CNT_OUT_W'(XW'(count_s1));

endmodule
`default_nettype wire
